// ===== design/cks_pkg.sv =====
// Shared types and constants for the 3x3 cross-kernel sharpen and edge filter.
package cks_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int DIM_W      = 11;
   localparam int POS_W      = 10;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_FILTER_MODE    = 2'd2;
   localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd3;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

   localparam logic MODE_SHARPEN = 1'b0;
   localparam logic MODE_EDGE    = 1'b1;

   // results one input item can release, in delivery order
   localparam logic [2:0] RES_ABOVE = 3'b001;
   localparam logic [2:0] RES_LEFT  = 3'b010;
   localparam logic [2:0] RES_HERE  = 3'b100;

   typedef struct packed {
      logic [CHAN_W-1:0] pix_r;
      logic [CHAN_W-1:0] pix_g;
      logic [CHAN_W-1:0] pix_b;
   } cks_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_r;
      logic [CHAN_W-1:0] out_g;
      logic [CHAN_W-1:0] out_b;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic              run_last;
      logic              frame_done;
   } cks_rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]  frame_width;
      logic [DIM_W-1:0]  frame_height;
      logic              filter_mode;
      logic [CHAN_W-1:0] edge_threshold;
   } cks_cfg_type;

   // neighbors fetched from the two line stores for one item
   typedef struct packed {
      logic [PIX_W-1:0] up_m2;
      logic [PIX_W-1:0] up_0;
      logic [PIX_W-1:0] mid_m1;
      logic [PIX_W-1:0] mid_0;
      logic [PIX_W-1:0] mid_p1;
   } cks_window_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] prev;
      cks_window_type   win;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [2:0]       res_mask;
      logic             row_is0;
      logic             row_is1;
      logic             col_nz;
   } cks_step_type;

endpackage

// ===== design/cks_csr.sv =====
// Configuration register file behind the APB-style port.
module cks_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cks_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cks_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cks_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output cks_pkg::cks_cfg_type            cfg,
   output logic                            cfg_wr
);
   import cks_pkg::*;

   cks_cfg_type cfg_ff, cfg_in;
   logic [1:0]  reg_idx;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (reg_idx)
            REG_FRAME_WIDTH:    cfg_in.frame_width    = csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg_in.frame_height   = csr_pwdata[DIM_W-1:0];
            REG_FILTER_MODE:    cfg_in.filter_mode    = csr_pwdata[0];
            REG_EDGE_THRESHOLD: cfg_in.edge_threshold = csr_pwdata[CHAN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FRAME_WIDTH:    csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:   csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_FILTER_MODE:    csr_prdata = CSR_DATA_W'(cfg_ff.filter_mode);
         REG_EDGE_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.edge_threshold);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= FRAME_WIDTH_RST;
         cfg_ff.frame_height   <= FRAME_HEIGHT_RST;
         cfg_ff.filter_mode    <= MODE_SHARPEN;
         cfg_ff.edge_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/cks_line_buf.sv =====
// Two swapping line stores, split by column parity, with registered neighbor prefetch.
module cks_line_buf #(
   parameter int COL_W = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic                       wr_line,
   input  logic [COL_W-1:0]           wr_col,
   input  logic [cks_pkg::PIX_W-1:0]  wr_data,
   input  logic                       rd_line,
   input  logic [COL_W-1:0]           rd_col,
   input  logic [COL_W-1:0]           rd_last,
   output cks_pkg::cks_window_type    win
);
   import cks_pkg::*;

   localparam int BANK_W     = COL_W - 1;
   localparam int BANK_DEPTH = 2 ** BANK_W;
   localparam int NUM_BANKS  = 4;

   logic [COL_W-1:0]  col_m1, col_p1, col_m2;
   logic [BANK_W-1:0] near_a, near_b, far_a, far_b;
   logic [PIX_W-1:0]  word_a [NUM_BANKS];
   logic [PIX_W-1:0]  word_b [NUM_BANKS];
   logic [PIX_W-1:0]  fwd_pix_ff;
   logic              upsel_ff, par_ff, at0_ff, at1_ff, atlast_ff;
   logic [1:0]        up_near, up_far, mid_near, mid_far;

   // near bank holds the column's own parity, far bank the neighbors on either side
   assign col_m1 = rd_col - COL_W'(1);
   assign col_p1 = rd_col + COL_W'(1);
   assign col_m2 = rd_col - COL_W'(2);
   assign near_a = rd_col[COL_W-1:1];
   assign near_b = col_m2[COL_W-1:1];
   assign far_a  = col_m1[COL_W-1:1];
   assign far_b  = col_p1[COL_W-1:1];

   for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
      localparam logic BANK_LINE = 1'(gb / 2);
      localparam logic BANK_PAR  = 1'(gb % 2);

      logic [PIX_W-1:0]  mem [BANK_DEPTH];
      logic [PIX_W-1:0]  q_a_ff, q_b_ff;
      logic              fwd_a_ff, fwd_b_ff;
      logic [BANK_W-1:0] addr_a, addr_b;
      logic              near, wr_here;

      assign near    = (rd_col[0] == BANK_PAR);
      assign addr_a  = near ? near_a : far_a;
      assign addr_b  = near ? near_b : far_b;
      assign wr_here = wr_en && (wr_line == BANK_LINE) && (wr_col[0] == BANK_PAR);

      always_ff @(posedge clock) begin
         if (wr_here) begin
            mem[wr_col[COL_W-1:1]] <= wr_data;
         end
         q_a_ff   <= mem[addr_a];
         q_b_ff   <= mem[addr_b];
         // take the item being written when the read hits the same entry
         fwd_a_ff <= wr_here && (addr_a == wr_col[COL_W-1:1]);
         fwd_b_ff <= wr_here && (addr_b == wr_col[COL_W-1:1]);
      end

      assign word_a[gb] = fwd_a_ff ? fwd_pix_ff : q_a_ff;
      assign word_b[gb] = fwd_b_ff ? fwd_pix_ff : q_b_ff;
   end

   always_ff @(posedge clock) begin
      fwd_pix_ff <= wr_data;
      upsel_ff   <= rd_line;
      par_ff     <= rd_col[0];
      at0_ff     <= (rd_col == '0);
      at1_ff     <= (rd_col == COL_W'(1));
      atlast_ff  <= (rd_col == rd_last);
   end

   assign up_near  = {upsel_ff, par_ff};
   assign up_far   = {upsel_ff, ~par_ff};
   assign mid_near = {~upsel_ff, par_ff};
   assign mid_far  = {~upsel_ff, ~par_ff};

   always_comb begin
      win.mid_0  = word_a[mid_near];
      win.mid_m1 = at0_ff ? word_a[mid_near] : word_a[mid_far];
      win.mid_p1 = atlast_ff ? word_a[mid_near] : word_b[mid_far];
      win.up_0   = word_a[up_near];
      if (at0_ff) begin
         win.up_m2 = word_a[up_near];
      end else if (at1_ff) begin
         win.up_m2 = word_a[up_far];
      end else begin
         win.up_m2 = word_b[up_near];
      end
   end

endmodule

// ===== design/cks_emit.sv =====
// Holds one item's neighborhood and issues its results through the kernel into the result register.
module cks_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_valid,
   input  cks_pkg::cks_step_type step,
   input  cks_pkg::cks_cfg_type  cfg,
   output logic                  step_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cks_pkg::cks_rsp_type  rsp_data
);
   import cks_pkg::*;

   localparam logic [15:0] GRAY_R   = 16'd77;
   localparam logic [15:0] GRAY_G   = 16'd150;
   localparam logic [15:0] GRAY_B   = 16'd29;
   localparam logic [15:0] GRAY_RND = 16'd128;

   function automatic logic [CHAN_W-1:0] gray8(input logic [PIX_W-1:0] p);
      logic [15:0] acc;
      acc = 16'(p[23:16]) * GRAY_R + 16'(p[15:8]) * GRAY_G + 16'(p[7:0]) * GRAY_B + GRAY_RND;
      return acc[15:8];
   endfunction

   // gain*ct minus the four neighbors, clamped to 0..255
   function automatic logic [CHAN_W-1:0] cross8(
      input logic [CHAN_W-1:0] up,
      input logic [CHAN_W-1:0] lf,
      input logic [CHAN_W-1:0] ct,
      input logic [CHAN_W-1:0] rt,
      input logic [CHAN_W-1:0] dn,
      input logic              gain5
   );
      logic [11:0]        pos, neg;
      logic signed [11:0] diff;
      pos  = {2'b00, ct, 2'b00} + (gain5 ? 12'(ct) : 12'd0);
      neg  = 12'(up) + 12'(lf) + 12'(rt) + 12'(dn);
      diff = signed'(pos - neg);
      if (diff < 0) begin
         return '0;
      end else if (diff > 12'sd255) begin
         return '1;
      end
      return diff[CHAN_W-1:0];
   endfunction

   cks_step_type     step_ff;
   logic [2:0]       pend_ff, pend_in;
   logic [2:0]       lowest, remaining;
   logic             issue;
   logic             rsp_valid_ff, rsp_valid_in;
   cks_rsp_type      rsp_data_ff, res;
   logic [PIX_W-1:0] nb_up, nb_lf, nb_ct, nb_rt, nb_dn;
   logic [CHAN_W-1:0] g_val;

   assign lowest     = pend_ff & (~pend_ff + 3'd1);
   assign remaining  = pend_ff & ~lowest;
   assign issue      = (pend_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign step_ready = (pend_ff == '0) || (issue && (remaining == '0));

   always_comb begin
      if (step_valid) begin
         pend_in = step.res_mask;
      end else if (issue) begin
         pend_in = remaining;
      end else begin
         pend_in = pend_ff;
      end
   end

   // pick the neighborhood of the next result
   always_comb begin
      res.out_row    = step_ff.row;
      res.out_col    = step_ff.col;
      res.frame_done = 1'b0;
      res.run_last   = (remaining == '0);
      case (lowest)
         RES_ABOVE: begin
            nb_up       = step_ff.row_is1 ? step_ff.win.mid_0 : step_ff.win.up_0;
            nb_lf       = step_ff.win.mid_m1;
            nb_ct       = step_ff.win.mid_0;
            nb_rt       = step_ff.win.mid_p1;
            nb_dn       = step_ff.pix;
            res.out_row = step_ff.row - POS_W'(1);
         end
         RES_LEFT: begin
            nb_up       = step_ff.row_is0 ? step_ff.prev : step_ff.win.mid_m1;
            nb_lf       = step_ff.win.up_m2;
            nb_ct       = step_ff.prev;
            nb_rt       = step_ff.pix;
            nb_dn       = step_ff.prev;
            res.out_col = step_ff.col - POS_W'(1);
         end
         default: begin
            nb_up          = step_ff.row_is0 ? step_ff.pix : step_ff.win.mid_0;
            nb_lf          = step_ff.col_nz ? step_ff.prev : step_ff.pix;
            nb_ct          = step_ff.pix;
            nb_rt          = step_ff.pix;
            nb_dn          = step_ff.pix;
            res.frame_done = 1'b1;
         end
      endcase

      g_val = cross8(gray8(nb_up), gray8(nb_lf), gray8(nb_ct), gray8(nb_rt), gray8(nb_dn),
                     1'b0);
      if (cfg.filter_mode == MODE_EDGE) begin
         res.out_r = (g_val > cfg.edge_threshold) ? '1 : '0;
         res.out_g = res.out_r;
         res.out_b = res.out_r;
      end else begin
         res.out_r = cross8(nb_up[23:16], nb_lf[23:16], nb_ct[23:16], nb_rt[23:16],
                            nb_dn[23:16], 1'b1);
         res.out_g = cross8(nb_up[15:8], nb_lf[15:8], nb_ct[15:8], nb_rt[15:8],
                            nb_dn[15:8], 1'b1);
         res.out_b = cross8(nb_up[7:0], nb_lf[7:0], nb_ct[7:0], nb_rt[7:0],
                            nb_dn[7:0], 1'b1);
      end
   end

   assign rsp_valid_in = issue || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid) begin
         step_ff <= step;
      end
      if (issue) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      ($countones(pend_ff) > 1) |-> !step_ready)
      else $error("item taken with results still queued");

   a_issue_fills_output: assert property (@(posedge clock) disable iff (reset)
      issue |=> rsp_valid_ff)
      else $error("issued result not presented");
`endif

endmodule

// ===== design/cross_kernel_sharpen_edge_3x3.sv =====
// 3x3 cross filter (sharpen, or gray edge detect with threshold) on a raster RGB
// stream. Pixels are taken one per clock unless the output or the line read holds
// them; the result for a pixel leaves once the pixel below it has arrived, and on the
// last row once the pixel to its right has arrived, so the last row releases up to
// three results per item and the input is held while the extra results go out, since
// the result register passes one result per clock when the consumer is ready.
// Neighbors come from two line stores, each split into even and odd column banks
// with two read ports, read ahead with the next column; a configuration write
// restarts that read, so the first item after it waits for the new read. Line
// contents are undefined after reset and are not cleared: the first rows of the
// first frame read only entries that have already been written.
module cross_kernel_sharpen_edge_3x3 #(
   parameter int MAX_WIDTH  = cks_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cks_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cks_pkg::cks_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cks_pkg::cks_rsp_type            rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cks_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cks_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cks_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import cks_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   cks_cfg_type      cfg;
   logic             cfg_wr;
   logic [COL_W-1:0] w_last, c_cur, c_next, col_ff, pf_col;
   logic [ROW_W-1:0] h_last, r_cur, r_next, row_ff;
   logic             sel_ff, sel_next, pf_line;
   logic             rd_vld_ff;
   logic [PIX_W-1:0] prev_ff, pix;
   logic             accept, row_end, last_row, step_ready;
   cks_window_type   win;
   cks_step_type     step;

   cks_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   // zero counts as one, oversize saturates to the maximum
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_last = '0;
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(cfg.frame_width - DIM_W'(1));
      end
      if (cfg.frame_height == '0) begin
         h_last = '0;
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(cfg.frame_height - DIM_W'(1));
      end
   end

   assign c_cur    = (col_ff > w_last) ? w_last : col_ff;
   assign r_cur    = (row_ff > h_last) ? h_last : row_ff;
   assign row_end  = (c_cur == w_last);
   assign last_row = (r_cur == h_last);
   assign c_next   = row_end ? '0 : c_cur + COL_W'(1);
   assign r_next   = !row_end ? r_cur : (last_row ? '0 : r_cur + ROW_W'(1));
   assign sel_next = sel_ff ^ row_end;

   assign pix       = {req_data.pix_r, req_data.pix_g, req_data.pix_b};
   assign req_ready = rd_vld_ff && step_ready;
   assign accept    = req_valid && req_ready;

   // prefetch for the item after this one, or keep reading the current column
   assign pf_col  = accept ? c_next : c_cur;
   assign pf_line = accept ? sel_next : sel_ff;

   cks_line_buf #(
      .COL_W (COL_W)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept),
      .wr_line (sel_ff),
      .wr_col  (c_cur),
      .wr_data (pix),
      .rd_line (pf_line),
      .rd_col  (pf_col),
      .rd_last (w_last),
      .win     (win)
   );

   always_comb begin
      step.pix      = pix;
      step.prev     = prev_ff;
      step.win      = win;
      step.row      = POS_W'(r_cur);
      step.col      = POS_W'(c_cur);
      step.res_mask = ((r_cur != '0) ? RES_ABOVE : '0)
                    | ((last_row && (c_cur != '0)) ? RES_LEFT : '0)
                    | ((last_row && row_end) ? RES_HERE : '0);
      step.row_is0  = (r_cur == '0);
      step.row_is1  = (r_cur == ROW_W'(1));
      step.col_nz   = (c_cur != '0);
   end

   cks_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .step_valid (accept),
      .step       (step),
      .cfg        (cfg),
      .step_ready (step_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         sel_ff    <= 1'b0;
         prev_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         // a register write may move the column, so drop the prefetched window
         rd_vld_ff <= !cfg_wr;
         if (accept) begin
            col_ff  <= c_next;
            row_ff  <= r_next;
            sel_ff  <= sel_next;
            prev_ff <= pix;
         end
      end
   end

`ifndef SYNTHESIS
   a_wait_for_window: assert property (@(posedge clock) disable iff (reset)
      !rd_vld_ff |-> !req_ready)
      else $error("item taken before the line read settled");

   a_cfg_drops_window: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !rd_vld_ff)
      else $error("window kept across a register write");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      accept |=> (col_ff <= $past(w_last)))
      else $error("column advanced past the row end");
`endif

endmodule
